// File: rtl/pn3_pkg.sv
// Shared widths, codes and control bundles of the 3D gradient noise pipeline.
package pn3_pkg;

    localparam int COORD_W = 32;
    localparam int PERM_W  = 8;
    localparam int OUT_W   = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        GRAD_XPY   = 3'd0,
        GRAD_NXPY  = 3'd1,
        GRAD_XNY   = 3'd2,
        GRAD_NXNY  = 3'd3,
        GRAD_XPZ   = 3'd4,
        GRAD_NXPZ  = 3'd5,
        GRAD_XNZ   = 3'd6,
        GRAD_NXNZ  = 3'd7
    } t_grad;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_fade_en;

    typedef struct packed {
        logic mul;
        logic add;
    } t_lerp_en;

endpackage

// File: rtl/pn3_if.sv
// Valid/ready channel interfaces for noise requests and noise results.
interface pn3_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic        [pn3_pkg::PERM_W-1:0]   perm_index;
    logic        [pn3_pkg::PERM_W-1:0]   perm_value;
    logic signed [pn3_pkg::COORD_W-1:0]  coord_x;
    logic signed [pn3_pkg::COORD_W-1:0]  coord_y;
    logic signed [pn3_pkg::COORD_W-1:0]  coord_z;

    modport source (output valid, op, perm_index, perm_value, coord_x, coord_y, coord_z,
                    input ready);
    modport sink   (input valid, op, perm_index, perm_value, coord_x, coord_y, coord_z,
                    output ready);
endinterface

interface pn3_out_if;
    logic                          valid;
    logic                          ready;
    logic [pn3_pkg::OUT_W-1:0]     noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

// File: rtl/perlin_noise_3d.sv
// Top level of the pipelined 3D gradient noise evaluator with permutation table load.
//
//  Channel  Dir  Payload                                                Role
//  i_in     in   op, perm_index, perm_value, coord_x, coord_y, coord_z  request item
//  o_out    out  noise_value                                            result item
//
// One item enters per cycle when no stage stalls; only evaluate items reach the output.
// The hash chain reads seven replicated table copies (one for x, two for y, four for z), two read ports each.
// Each copy is written as a load item passes its stage, so table order follows item order.
// Reset clears only the stage valid bits; the table holds nothing until loaded.
// Each stage advances when it is empty or the next one advances, so a stall holds every item.
module perlin_noise_3d #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pn3_in_if.sink        i_in,
    pn3_out_if.source     o_out
);

    localparam int F  = FRAC_BITS;
    localparam int TW = $clog2(TABLE_SIZE);
    localparam int GW = F + 3;
    localparam int NS = 12;
    localparam int PW = pn3_pkg::PERM_W;
    localparam logic signed [GW-1:0] ONE_G = GW'(1) << F;
    localparam logic [F:0] ONE_F = (F+1)'(1) << F;

    logic [NS:1]   r_v;
    logic [NS+1:1] en;

    logic                  r_op1, r_op2, r_op3, r_op4;
    logic [TW-1:0]         r_pidx1, r_pidx2, r_pidx3;
    logic [PW-1:0]         r_pval1, r_pval2, r_pval3;
    logic [TW-1:0]         r_cell1 [3];
    logic [F-1:0]          r_frac1 [3];
    logic [F-1:0]          r_frac2 [3];
    logic [F-1:0]          r_frac3 [3];
    logic [F-1:0]          r_frac4 [3];
    logic [TW-1:0]         r_cy2, r_cz2, r_cz3;
    logic signed [pn3_pkg::COORD_W-1:0] coord [3];
    logic signed [pn3_pkg::COORD_W-1:0] cell_sh [3];

    logic [PW-1:0]         px0, px1, pa0, pa1, pb0, pb1;
    logic [TW-1:0]         addr_a, addr_b;
    logic [TW-1:0]         base [4];
    logic [PW-1:0]         hash [8];

    logic signed [GW-1:0]  n_g [8];
    logic signed [GW-1:0]  r_g5 [8];
    logic [F:0]            fade [3];
    logic [F:0]            r_tv6, r_tv7, r_tw6, r_tw7, r_tw8, r_tw9;
    logic signed [GW-1:0]  xr [4];
    logic signed [GW-1:0]  yr [2];
    logic signed [GW-1:0]  zr;
    logic signed [GW:0]    s_map;
    logic [GW+14:0]        q_wide;
    logic [pn3_pkg::OUT_W-1:0] n_noise, r_noise;

    pn3_pkg::t_fade_en     fade_en;
    pn3_pkg::t_lerp_en     lx_en, ly_en, lz_en;

    logic we0, we12, we36;

    function automatic logic [TW-1:0] hsum(input logic [PW-1:0] p, input logic [TW-1:0] c);
        logic [TW+PW-1:0] s;
        s = {{TW{1'b0}}, p} + {{PW{1'b0}}, c};
        return s[TW-1:0];
    endfunction

    function automatic logic signed [GW-1:0] offs(input logic [F-1:0] f, input logic hi);
        logic signed [GW-1:0] e;
        e = $signed({3'b000, f});
        return hi ? e - ONE_G : e;
    endfunction

    function automatic logic signed [GW-1:0] grad(input logic [2:0] h,
                                                  input logic signed [GW-1:0] x,
                                                  input logic signed [GW-1:0] y,
                                                  input logic signed [GW-1:0] z);
        logic signed [GW-1:0] g;
        case (pn3_pkg::t_grad'(h))
            pn3_pkg::GRAD_XPY:  g = x + y;
            pn3_pkg::GRAD_NXPY: g = y - x;
            pn3_pkg::GRAD_XNY:  g = x - y;
            pn3_pkg::GRAD_NXNY: g = -x - y;
            pn3_pkg::GRAD_XPZ:  g = x + z;
            pn3_pkg::GRAD_NXPZ: g = z - x;
            pn3_pkg::GRAD_XNZ:  g = x - z;
            default:            g = -x - z;
        endcase
        return g;
    endfunction

    // Stage enables: a stage loads when it is empty or its successor loads.
    always_comb begin
        en[NS+1] = o_out.ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready  = en[1];
    assign o_out.valid = r_v[NS];
    assign o_out.noise_value = r_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (en[k]) begin
                    if (k == 1) begin
                        r_v[k] <= i_in.valid;
                    end else if (k == 5) begin
                        r_v[k] <= r_v[4] && (r_op4 == pn3_pkg::OP_EVAL);
                    end else begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end
        end
    end

    assign coord[0] = i_in.coord_x;
    assign coord[1] = i_in.coord_y;
    assign coord[2] = i_in.coord_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cell_sh[a] = coord[a] >>> F;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_op1   <= i_in.op;
            r_pidx1 <= TW'({{TW{1'b0}}, i_in.perm_index});
            r_pval1 <= i_in.perm_value;
            for (int a = 0; a < 3; a++) begin
                r_cell1[a] <= cell_sh[a][TW-1:0];
                r_frac1[a] <= coord[a][F-1:0];
            end
        end
        if (en[2]) begin
            r_op2   <= r_op1;
            r_pidx2 <= r_pidx1;
            r_pval2 <= r_pval1;
            r_cy2   <= r_cell1[1];
            r_cz2   <= r_cell1[2];
            r_frac2 <= r_frac1;
        end
        if (en[3]) begin
            r_op3   <= r_op2;
            r_pidx3 <= r_pidx2;
            r_pval3 <= r_pval2;
            r_cz3   <= r_cz2;
            r_frac3 <= r_frac2;
        end
        if (en[4]) begin
            r_op4   <= r_op3;
            r_frac4 <= r_frac3;
        end
    end

    assign we0  = en[2] && r_v[1] && (r_op1 == pn3_pkg::OP_LOAD);
    assign we12 = en[3] && r_v[2] && (r_op2 == pn3_pkg::OP_LOAD);
    assign we36 = en[4] && r_v[3] && (r_op3 == pn3_pkg::OP_LOAD);

    pn3_ram #(.ADDR_W(TW)) u_ram_x (
        .i_clk(i_clk), .i_we(we0), .i_waddr(r_pidx1), .i_wdata(r_pval1),
        .i_re(en[2]), .i_raddr0(r_cell1[0]), .i_raddr1(r_cell1[0] + TW'(1)),
        .o_rdata0(px0), .o_rdata1(px1)
    );

    assign addr_a = hsum(px0, r_cy2);
    assign addr_b = hsum(px1, r_cy2);

    pn3_ram #(.ADDR_W(TW)) u_ram_a (
        .i_clk(i_clk), .i_we(we12), .i_waddr(r_pidx2), .i_wdata(r_pval2),
        .i_re(en[3]), .i_raddr0(addr_a), .i_raddr1(addr_a + TW'(1)),
        .o_rdata0(pa0), .o_rdata1(pa1)
    );

    pn3_ram #(.ADDR_W(TW)) u_ram_b (
        .i_clk(i_clk), .i_we(we12), .i_waddr(r_pidx2), .i_wdata(r_pval2),
        .i_re(en[3]), .i_raddr0(addr_b), .i_raddr1(addr_b + TW'(1)),
        .o_rdata0(pb0), .o_rdata1(pb1)
    );

    // Corner bases ordered by x bit then y bit: AA, BA, AB, BB.
    assign base[0] = hsum(pa0, r_cz3);
    assign base[1] = hsum(pb0, r_cz3);
    assign base[2] = hsum(pa1, r_cz3);
    assign base[3] = hsum(pb1, r_cz3);

    for (genvar j = 0; j < 4; j++) begin : g_corner
        pn3_ram #(.ADDR_W(TW)) u_ram_c (
            .i_clk(i_clk), .i_we(we36), .i_waddr(r_pidx3), .i_wdata(r_pval3),
            .i_re(en[4]), .i_raddr0(base[j]), .i_raddr1(base[j] + TW'(1)),
            .o_rdata0(hash[j]), .o_rdata1(hash[j+4])
        );
    end

    assign fade_en = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5]};

    for (genvar a = 0; a < 3; a++) begin : g_fade
        pn3_fade #(.FRAC_BITS(F)) u_fade (
            .i_clk(i_clk), .i_en(fade_en), .i_t(r_frac1[a]), .o_fade(fade[a])
        );
    end

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            n_g[c] = grad(hash[c][2:0], offs(r_frac4[0], c[0]),
                          offs(r_frac4[1], c[1]), offs(r_frac4[2], c[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_g5 <= n_g;
        end
        if (en[6]) begin
            r_tv6 <= fade[1];
            r_tw6 <= fade[2];
        end
        if (en[7]) begin
            r_tv7 <= r_tv6;
            r_tw7 <= r_tw6;
        end
        if (en[8]) begin
            r_tw8 <= r_tw7;
        end
        if (en[9]) begin
            r_tw9 <= r_tw8;
        end
        if (en[NS]) begin
            r_noise <= n_noise;
        end
    end

    assign lx_en = '{mul: en[6], add: en[7]};
    assign ly_en = '{mul: en[8], add: en[9]};
    assign lz_en = '{mul: en[10], add: en[11]};

    for (genvar j = 0; j < 4; j++) begin : g_lx
        pn3_lerp #(.FRAC_BITS(F)) u_lerp (
            .i_clk(i_clk), .i_en(lx_en), .i_t(fade[0]),
            .i_a(r_g5[2*j]), .i_b(r_g5[2*j+1]), .o_r(xr[j])
        );
    end

    for (genvar k = 0; k < 2; k++) begin : g_ly
        pn3_lerp #(.FRAC_BITS(F)) u_lerp (
            .i_clk(i_clk), .i_en(ly_en), .i_t(r_tv7),
            .i_a(xr[2*k]), .i_b(xr[2*k+1]), .o_r(yr[k])
        );
    end

    pn3_lerp #(.FRAC_BITS(F)) u_lz (
        .i_clk(i_clk), .i_en(lz_en), .i_t(r_tw9),
        .i_a(yr[0]), .i_b(yr[1]), .o_r(zr)
    );

    // Map (r + 1) / 2 onto unsigned Q0.16 and saturate at both ends.
    always_comb begin
        s_map  = {zr[GW-1], zr} + {ONE_G[GW-1], ONE_G};
        q_wide = {s_map[GW-1:0], 15'b0} >> F;
        if (s_map[GW] || (s_map == '0)) begin
            n_noise = '0;
        end else if (|q_wide[GW+14:16]) begin
            n_noise = '1;
        end else begin
            n_noise = q_wide[15:0];
        end
    end

    a_load_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en[5] && r_v[4] && (r_op4 == pn3_pkg::OP_LOAD)) |=> !r_v[5])
        else $error("load item reached the blend stages");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && !en[6]) |=> r_v[6])
        else $error("stalled item lost in stage six");

    a_fade_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] |-> (fade[0] <= ONE_F && fade[1] <= ONE_F && fade[2] <= ONE_F))
        else $error("fade result above one");

endmodule

// File: rtl/pn3_ram.sv
// Permutation table copy with one write port and two registered read ports.
module pn3_ram #(
    parameter int ADDR_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [pn3_pkg::PERM_W-1:0]   i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr0,
    input  logic [ADDR_W-1:0]            i_raddr1,
    output logic [pn3_pkg::PERM_W-1:0]   o_rdata0,
    output logic [pn3_pkg::PERM_W-1:0]   o_rdata1
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [pn3_pkg::PERM_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

// File: rtl/pn3_fade.sv
// Four-stage fade curve 6t^5-15t^4+10t^3 on one fractional coordinate.
module pn3_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  pn3_pkg::t_fade_en       i_en,
    input  logic [FRAC_BITS-1:0]    i_t,
    output logic [FRAC_BITS:0]      o_fade
);

    localparam int F  = FRAC_BITS;
    localparam int KW = F + 4;
    localparam logic [KW-1:0] K15 = KW'(15) << F;
    localparam logic [KW-1:0] K10 = KW'(10) << F;

    logic [KW-1:0]    k;
    logic [2*F+3:0]   r_mraw;
    logic [2*F-1:0]   r_t2raw;
    logic [F-1:0]     r_t;
    logic [KW-1:0]    r_inner;
    logic [2*F-1:0]   r_t3raw;
    logic [2*F+3:0]   r_fraw;

    assign k = K15 - (KW'({i_t, 2'b00}) + KW'({i_t, 1'b0}));

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_mraw  <= (2*F+4)'(i_t) * (2*F+4)'(k);
            r_t2raw <= (2*F)'(i_t) * (2*F)'(i_t);
            r_t     <= i_t;
        end
        if (i_en.s3) begin
            r_inner <= K10 - r_mraw[2*F+3:F];
            r_t3raw <= (2*F)'(r_t2raw[2*F-1:F]) * (2*F)'(r_t);
        end
        if (i_en.s4) begin
            r_fraw <= (2*F+4)'(r_t3raw[2*F-1:F]) * (2*F+4)'(r_inner);
        end
        if (i_en.s5) begin
            o_fade <= r_fraw[2*F:F];
        end
    end

endmodule

// File: rtl/pn3_lerp.sv
// Two-stage linear blend a + floor(t * (b - a)) in signed fixed point.
module pn3_lerp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  pn3_pkg::t_lerp_en             i_en,
    input  logic        [FRAC_BITS:0]     i_t,
    input  logic signed [FRAC_BITS+2:0]   i_a,
    input  logic signed [FRAC_BITS+2:0]   i_b,
    output logic signed [FRAC_BITS+2:0]   o_r
);

    localparam int F  = FRAC_BITS;
    localparam int GW = F + 3;

    logic signed [GW:0]      diff;
    logic signed [2*F+5:0]   r_prod;
    logic signed [GW-1:0]    r_a;
    logic signed [2*F+5:0]   prod_sh;
    logic signed [F+5:0]     sum;

    assign diff    = {i_b[GW-1], i_b} - {i_a[GW-1], i_a};
    assign prod_sh = r_prod >>> F;
    assign sum     = {{3{r_a[GW-1]}}, r_a} + prod_sh[F+5:0];

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_prod <= (2*F+6)'($signed({1'b0, i_t}) * diff);
            r_a    <= i_a;
        end
        if (i_en.add) begin
            o_r <= sum[GW-1:0];
        end
    end

endmodule
